FILE: hdl/vmt_pkg.sv
// Shared constants for the vector move-towards block.
`default_nettype none
package vmt_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRACTION_BITS = 12;
endpackage
`default_nettype wire

FILE: hdl/vmt_if.sv
// Request and response channel interfaces for the vector move-towards block.
`default_nettype none
interface vmt_req_if #(
  parameter int WORD_BITS = vmt_pkg::WORD_BITS
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] current_x;
  logic signed [WORD_BITS-1:0] current_y;
  logic signed [WORD_BITS-1:0] target_x;
  logic signed [WORD_BITS-1:0] target_y;
  logic signed [WORD_BITS-1:0] max_step;
  modport source (output valid, current_x, current_y, target_x, target_y, max_step,
                  input ready);
  modport sink (input valid, current_x, current_y, target_x, target_y, max_step,
                output ready);
endinterface

interface vmt_rsp_if #(
  parameter int WORD_BITS = vmt_pkg::WORD_BITS
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] new_x;
  logic signed [WORD_BITS-1:0] new_y;
  logic                        reached;
  logic                        fault;
  modport source (output valid, new_x, new_y, reached, fault, input ready);
  modport sink (input valid, new_x, new_y, reached, fault, output ready);
endinterface
`default_nettype wire

FILE: hdl/vmt_sqrt_cell.sv
// One root digit of the pipelined integer square root.
`default_nettype none
module vmt_sqrt_cell #(
  parameter int WORD_BITS = vmt_pkg::WORD_BITS,
  parameter int SIDE_W    = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      up_valid,
  input  wire logic [(WORD_BITS+1)/2+1:0] up_rem,
  input  wire logic [(WORD_BITS+1)/2-1:0] up_root,
  input  wire logic [2*((WORD_BITS+1)/2)-1:0] up_rad,
  input  wire logic [SIDE_W-1:0]         up_side,
  output logic                           dn_valid,
  output logic [(WORD_BITS+1)/2+1:0]     dn_rem,
  output logic [(WORD_BITS+1)/2-1:0]     dn_root,
  output logic [2*((WORD_BITS+1)/2)-1:0] dn_rad,
  output logic [SIDE_W-1:0]              dn_side
);
  localparam int H  = (WORD_BITS + 1) / 2;
  localparam int NP = 2 * H;

  logic [H+3:0] t;
  logic [H+3:0] trial;
  logic [H+1:0] rem_next;
  logic [H-1:0] root_next;

  always_comb begin
    t     = {up_rem, up_rad[NP-1 -: 2]};
    trial = {2'b00, up_root, 2'b01};
    if (t >= trial) begin
      rem_next  = (H+2)'(t - trial);
      root_next = {up_root[H-2:0], 1'b1};
    end else begin
      rem_next  = t[H+1:0];
      root_next = {up_root[H-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_rem  <= rem_next;
      dn_root <= root_next;
      dn_rad  <= {up_rad[NP-3:0], 2'b00};
      dn_side <= up_side;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/vmt_div_cell.sv
// One quotient bit of the two-lane pipelined restoring divider.
`default_nettype none
module vmt_div_cell #(
  parameter int WORD_BITS = vmt_pkg::WORD_BITS,
  parameter int NUM_BITS  = vmt_pkg::WORD_BITS + vmt_pkg::FRACTION_BITS,
  parameter int SIDE_W    = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          up_valid,
  input  wire logic [WORD_BITS-1:0]          up_div,
  input  wire logic [1:0][WORD_BITS-1:0]     up_rem,
  input  wire logic [1:0][NUM_BITS-1:0]      up_num,
  input  wire logic [1:0][WORD_BITS-1:0]     up_quo,
  input  wire logic [SIDE_W-1:0]             up_side,
  output logic                               dn_valid,
  output logic [WORD_BITS-1:0]               dn_div,
  output logic [1:0][WORD_BITS-1:0]          dn_rem,
  output logic [1:0][NUM_BITS-1:0]          dn_num,
  output logic [1:0][WORD_BITS-1:0]          dn_quo,
  output logic [SIDE_W-1:0]                  dn_side
);
  logic [1:0][WORD_BITS:0]   t;
  logic [1:0][WORD_BITS-1:0] rem_next;
  logic [1:0][WORD_BITS-1:0] quo_next;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t[l] = {up_rem[l], up_num[l][NUM_BITS-1]};
      if (t[l] >= {1'b0, up_div}) begin
        rem_next[l] = WORD_BITS'(t[l] - {1'b0, up_div});
        quo_next[l] = {up_quo[l][WORD_BITS-2:0], 1'b1};
      end else begin
        rem_next[l] = t[l][WORD_BITS-1:0];
        quo_next[l] = {up_quo[l][WORD_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_div  <= up_div;
      dn_rem  <= rem_next;
      dn_quo  <= quo_next;
      dn_side <= up_side;
      for (int l = 0; l < 2; l++) begin
        dn_num[l] <= {up_num[l][NUM_BITS-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/vector_move_towards_fixed_top.sv
// Top level of the vector move-towards block: pipeline, cell chains and output buffer.
//
// Moves a fixed-point 2D point towards a target by at most max_step. The block
// takes one request per cycle and returns one response per request, in order.
// The request flows through registered stages for differences, squares and the
// distance compare, one cell per root bit in the square-root chain, a divider setup
// stage, one cell per quotient bit in the two-lane divider chain, then the scaling
// multiply; the final add and select feed the output buffer. A two-entry output
// buffer lets the pipeline keep moving while a response waits; when both entries
// are full the pipeline holds and req.ready drops.
`default_nettype none
module vector_move_towards_fixed_top #(
  parameter int WORD_BITS     = vmt_pkg::WORD_BITS,
  parameter int FRACTION_BITS = vmt_pkg::FRACTION_BITS
) (
  input wire logic clk,
  input wire logic rst,
  vmt_req_if.sink  req,
  vmt_rsp_if.source rsp
);
  localparam int W      = WORD_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int H      = (W + 1) / 2;
  localparam int NP     = 2 * H;
  localparam int N      = W + F;
  localparam int SQ_SW  = 7 * W + 1;
  localparam int DV_SW  = 5 * W + 4;
  localparam int RSP_W  = 2 * W + 2;

  function automatic logic [W-1:0] fmul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = $signed(a) * $signed(b);
    return p[F+W-1:F];
  endfunction

  logic       adv;
  logic [1:0] cnt;

  // stage 1: differences
  logic         v1;
  logic [W-1:0] cx1, cy1, tx1, ty1, st1, dx1, dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx1 <= req.current_x;
      cy1 <= req.current_y;
      tx1 <= req.target_x;
      ty1 <= req.target_y;
      st1 <= req.max_step;
      dx1 <= W'(req.target_x - req.current_x);
      dy1 <= W'(req.target_y - req.current_y);
    end
  end

  // stage 2: squares
  logic         v2;
  logic [W-1:0] cx2, cy2, tx2, ty2, st2, dx2, dy2, pxx2, pyy2, pss2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {cx2, cy2, tx2, ty2, st2, dx2, dy2} <= {cx1, cy1, tx1, ty1, st1, dx1, dy1};
      pxx2 <= fmul(dx1, dx1);
      pyy2 <= fmul(dy1, dy1);
      pss2 <= fmul(st1, st1);
    end
  end

  // stage 3: squared distance and reach test
  logic         v3;
  logic [W-1:0] cx3, cy3, tx3, ty3, st3, dx3, dy3, rad3;
  logic         reached3;
  logic [W-1:0] d2;
  logic         reached_next;

  always_comb begin
    d2           = W'(pxx2 + pyy2);
    reached_next = (d2 == '0) || (!st2[W-1] && ($signed(d2) <= $signed(pss2)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {cx3, cy3, tx3, ty3, st3, dx3, dy3} <= {cx2, cy2, tx2, ty2, st2, dx2, dy2};
      rad3     <= d2[W-1] ? '0 : d2;
      reached3 <= reached_next;
    end
  end

  // square-root chain
  logic              sq_valid [H+1];
  logic [H+1:0]      sq_rem   [H+1];
  logic [H-1:0]      sq_root  [H+1];
  logic [NP-1:0]     sq_rad   [H+1];
  logic [SQ_SW-1:0]  sq_side  [H+1];

  assign sq_valid[0] = v3;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_rad[0]   = NP'(rad3);
  assign sq_side[0]  = {cx3, cy3, tx3, ty3, st3, dx3, dy3, reached3};

  for (genvar i = 0; i < H; i++) begin : g_sqrt
    vmt_sqrt_cell #(
      .WORD_BITS (W),
      .SIDE_W    (SQ_SW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .up_valid (sq_valid[i]),
      .up_rem   (sq_rem[i]),
      .up_root  (sq_root[i]),
      .up_rad   (sq_rad[i]),
      .up_side  (sq_side[i]),
      .dn_valid (sq_valid[i+1]),
      .dn_rem   (sq_rem[i+1]),
      .dn_root  (sq_root[i+1]),
      .dn_rad   (sq_rad[i+1]),
      .dn_side  (sq_side[i+1])
    );
  end

  // stage 4: divider setup
  logic [W-1:0] cx_s, cy_s, tx_s, ty_s, st_s, dx_s, dy_s;
  logic         reached_s;
  logic [W-1:0] root_dist;

  always_comb begin
    {cx_s, cy_s, tx_s, ty_s, st_s, dx_s, dy_s, reached_s} = sq_side[H];
    root_dist = W'({sq_root[H], {(F/2){1'b0}}});
  end

  logic         v4;
  logic [W-1:0] mb4, max4, may4;
  logic [W-1:0] cx4, cy4, tx4, ty4, st4;
  logic         reached4, fault4, sx4, sy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= sq_valid[H];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {cx4, cy4, tx4, ty4, st4} <= {cx_s, cy_s, tx_s, ty_s, st_s};
      reached4 <= reached_s;
      fault4   <= !reached_s && (root_dist == '0);
      mb4      <= root_dist[W-1] ? W'(-root_dist) : root_dist;
      max4     <= dx_s[W-1] ? W'(-dx_s) : dx_s;
      may4     <= dy_s[W-1] ? W'(-dy_s) : dy_s;
      sx4      <= dx_s[W-1] ^ root_dist[W-1];
      sy4      <= dy_s[W-1] ^ root_dist[W-1];
    end
  end

  // divider chain
  logic                 dv_valid [N+1];
  logic [W-1:0]         dv_div   [N+1];
  logic [1:0][W-1:0]    dv_rem   [N+1];
  logic [1:0][N-1:0]    dv_num   [N+1];
  logic [1:0][W-1:0]    dv_quo   [N+1];
  logic [DV_SW-1:0]     dv_side  [N+1];

  assign dv_valid[0] = v4;
  assign dv_div[0]   = mb4;
  assign dv_rem[0]   = '0;
  assign dv_num[0]   = {{may4, {F{1'b0}}}, {max4, {F{1'b0}}}};
  assign dv_quo[0]   = '0;
  assign dv_side[0]  = {cx4, cy4, tx4, ty4, st4, reached4, fault4, sx4, sy4};

  for (genvar i = 0; i < N; i++) begin : g_div
    vmt_div_cell #(
      .WORD_BITS (W),
      .NUM_BITS  (N),
      .SIDE_W    (DV_SW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .up_valid (dv_valid[i]),
      .up_div   (dv_div[i]),
      .up_rem   (dv_rem[i]),
      .up_num   (dv_num[i]),
      .up_quo   (dv_quo[i]),
      .up_side  (dv_side[i]),
      .dn_valid (dv_valid[i+1]),
      .dn_div   (dv_div[i+1]),
      .dn_rem   (dv_rem[i+1]),
      .dn_num   (dv_num[i+1]),
      .dn_quo   (dv_quo[i+1]),
      .dn_side  (dv_side[i+1])
    );
  end

  // stage 5: signed quotient times step
  logic [W-1:0] cx_d, cy_d, tx_d, ty_d, st_d;
  logic         reached_d, fault_d, sx_d, sy_d;
  logic [W-1:0] qx, qy;

  always_comb begin
    {cx_d, cy_d, tx_d, ty_d, st_d, reached_d, fault_d, sx_d, sy_d} = dv_side[N];
    qx = sx_d ? W'(-dv_quo[N][0]) : dv_quo[N][0];
    qy = sy_d ? W'(-dv_quo[N][1]) : dv_quo[N][1];
  end

  logic         v5;
  logic [W-1:0] cx5, cy5, tx5, ty5, mx5, my5;
  logic         reached5, fault5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= dv_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {cx5, cy5, tx5, ty5} <= {cx_d, cy_d, tx_d, ty_d};
      reached5 <= reached_d;
      fault5   <= fault_d;
      mx5      <= fmul(qx, st_d);
      my5      <= fmul(qy, st_d);
    end
  end

  // final select
  logic [W-1:0]     nx, ny;
  logic [RSP_W-1:0] result;

  always_comb begin
    if (reached5) begin
      nx = tx5;
      ny = ty5;
    end else if (fault5) begin
      nx = cx5;
      ny = cy5;
    end else begin
      nx = W'(cx5 + mx5);
      ny = W'(cy5 + my5);
    end
    result = {nx, ny, reached5, fault5};
  end

  // output buffer
  logic [RSP_W-1:0] head, tail;
  logic             push, pop;
  logic [1:0]       cnt_left;

  assign adv       = (cnt != 2'd2);
  assign req.ready = adv;
  assign push      = adv && v5;
  assign pop       = rsp.valid && rsp.ready;
  assign cnt_left  = cnt - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_left == 2'd0)) begin
      head <= result;
    end else if (pop) begin
      head <= tail;
    end
    if (push && (cnt_left != 2'd0)) begin
      tail <= result;
    end
  end

  assign rsp.valid = (cnt != 2'd0);
  assign {rsp.new_x, rsp.new_y, rsp.reached, rsp.fault} = head;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !req.ready)
    else $error("request taken while output buffer full");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.reached && rsp.fault))
    else $error("reached and fault both set");
  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.new_x) && $stable(rsp.new_y))
    else $error("response changed while stalled");
endmodule
`default_nettype wire

FILE: tb/vector_move_towards_fixed_top_test.sv
// Testbench for vector_move_towards_fixed_top: random and directed point moves checked by a scoreboard.
`timescale 1ns / 1ps
module vector_move_towards_fixed_top_test;

  typedef logic signed [vmt_pkg::WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t cx;
    word_t cy;
    word_t tx;
    word_t ty;
    word_t step;
  } move_req_t;

  typedef struct packed {
    word_t nx;
    word_t ny;
    logic  reached;
    logic  fault;
  } move_rsp_t;

  class move_scoreboard;
    move_rsp_t pending[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    function word_t fx_mul(word_t a, word_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return word_t'(p >>> vmt_pkg::FRACTION_BITS);
    endfunction

    function word_t fx_div(word_t a, word_t b);
      longint n;
      n = longint'(a) * (64'sd1 << vmt_pkg::FRACTION_BITS);
      return word_t'(n / longint'(b));
    endfunction

    function word_t fx_root(word_t r);
      longint unsigned v;
      longint unsigned res;
      longint unsigned bitv;
      v = 0;
      res = 0;
      bitv = 64'd1 << 62;
      if (r < 0) return '0;
      v = longint'(r);
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return word_t'(res << (vmt_pkg::FRACTION_BITS / 2));
    endfunction

    function move_rsp_t predict_move(move_req_t q);
      move_rsp_t o;
      word_t dx, dy, d2, dist_w;
      dx = q.tx - q.cx;
      dy = q.ty - q.cy;
      d2 = fx_mul(dx, dx) + fx_mul(dy, dy);
      o = '0;
      if (d2 == 0 || (q.step >= 0 && d2 <= fx_mul(q.step, q.step))) begin
        o.nx = q.tx;
        o.ny = q.ty;
        o.reached = 1'b1;
      end else begin
        dist_w = fx_root(d2);
        if (dist_w == 0) begin
          o.nx = q.cx;
          o.ny = q.cy;
          o.fault = 1'b1;
        end else begin
          o.nx = q.cx + fx_mul(fx_div(dx, dist_w), q.step);
          o.ny = q.cy + fx_mul(fx_div(dy, dist_w), q.step);
        end
      end
      return o;
    endfunction

    function void note_request(move_req_t q);
      pending.push_back(predict_move(q));
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_response(move_rsp_t r);
      move_rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected response", r.nx, 0);
        return;
      end
      e = pending.pop_front();
      if (r.nx !== e.nx) report("new_x", r.nx, e.nx);
      if (r.ny !== e.ny) report("new_y", r.ny, e.ny);
      if (r.reached !== e.reached) report("reached", r.reached, e.reached);
      if (r.fault !== e.fault) report("fault", r.fault, e.fault);
    endtask
  endclass

  logic clk;
  logic rst;
  vmt_req_if req ();
  vmt_rsp_if rsp ();

  vector_move_towards_fixed_top DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  move_scoreboard sb;
  int phase;
  int idle_cycles;
  bit send_done;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function word_t pick_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      default: return word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task send_move(move_req_t q);
    int gap_pct;
    gap_pct = (phase == 0) ? 10 : (phase == 1) ? 85 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      req.valid = 1'b0;
    end
    @(negedge clk);
    req.valid = 1'b1;
    req.current_x = q.cx;
    req.current_y = q.cy;
    req.target_x = q.tx;
    req.target_y = q.ty;
    req.max_step = q.step;
    do @(posedge clk); while (!req.ready);
    sb.note_request(q);
  endtask

  task send_random(int n);
    move_req_t q;
    repeat (n) begin
      q.cx = pick_word();
      q.cy = pick_word();
      q.tx = pick_word();
      q.ty = pick_word();
      q.step = pick_word();
      if ($urandom_range(0, 3) == 0) q.tx = q.cx + word_t'($urandom_range(0, 64)) - 32;
      send_move(q);
    end
  endtask

  task send_directed();
    word_t ext[4];
    ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'shffffffff};
    send_move('{32'sh1000, 32'sh2000, 32'sh1000, 32'sh2000, 32'sh0});
    send_move('{32'sh1000, 32'sh2000, 32'sh1000, 32'sh2000, -32'sh1000});
    send_move('{32'sh0, 32'sh0, 32'sh3000, 32'sh4000, 32'sh5000});
    send_move('{32'sh0, 32'sh0, 32'sh3000, 32'sh4000, 32'sh6000});
    send_move('{32'sh0, 32'sh0, 32'sh3000, 32'sh4000, 32'sh1000});
    send_move('{32'sh0, 32'sh0, 32'sh3000, 32'sh4000, -32'sh1000});
    send_move('{32'sh0, 32'sh0, 32'sh00100000, 32'sh0, 32'sh1000});
    send_move('{32'sh0, 32'sh0, 32'sh00300000, 32'sh00300000, 32'sh1000});
    foreach (ext[i])
      foreach (ext[j])
        send_move('{ext[i], ext[j], ext[j], ext[i], ext[(i + j) % 4]});
  endtask

  initial begin
    sb = new();
    phase = 0;
    send_done = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.current_x = '0;
    req.current_y = '0;
    req.target_x = '0;
    req.target_y = '0;
    req.max_step = '0;
    rsp.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_directed();
    send_random(160);
    phase = 1;
    send_random(160);
    phase = 2;
    send_random(180);
    @(negedge clk);
    req.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst) begin
      case (phase)
        0: rsp.ready <= ($urandom_range(0, 99) >= 85);
        1: rsp.ready <= ($urandom_range(0, 99) >= 10);
        default: rsp.ready <= 1'b1;
      endcase
    end
  end

  // check each response transfer; watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        sb.check_response('{rsp.new_x, rsp.new_y, rsp.reached, rsp.fault});
      if ((rsp.valid && rsp.ready) || (req.valid && req.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("Verification failed");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end
endmodule
